>>> src/plsrc_pkg.sv
// ----------------------------------------------------------------------------
// plsrc_pkg: shared types and constants for the piecewise-linear source
// Field widths, op and region codes, and the divider request/response types.
// ----------------------------------------------------------------------------
package plsrc_pkg;

  localparam int MAX_POINTS_DEF = 16;

  localparam int TIME_W   = 32;
  localparam int VOLT_W   = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int REGION_W = 2;
  localparam int PROD_W   = 2 * TIME_W;
  localparam int QUOT_W   = TIME_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd0;
  localparam logic [REGION_W-1:0] REGION_BEFORE = 2'd1;
  localparam logic [REGION_W-1:0] REGION_AFTER  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> src/piecewise_linear_source_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_source_top: piecewise-linear voltage source evaluator
//
// Input channel (in_valid/in_ready) carries one item per transfer: op selects
// a breakpoint write (point_index, point_time, point_volts) or a query
// (query_time). Writes land in the table at the transfer and give no result.
// A query gives one result (volts_out, region) on the out_valid/out_ready
// channel. cfg_we/cfg_wdata set the number of breakpoints in use; write it
// only while the block is idle.
// A query scans the table one entry per cycle through the RAM read port
// and stops at the first matching segment k (0-based); times outside the
// table scan all n points in use. When a division is needed the query
// goes on through S_MUL and S_DIVGO to the 32-step serial divider.
// The block holds in_ready low while a query is in flight; one finished
// result may wait in the output register while the next item is taken.
// A stalled receiver only holds the next query at its final step.
// Reset clears the sequencer and output valid and sets the point count to 1;
// table contents are undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_source_top #(
  parameter int MAX_POINTS = plsrc_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [plsrc_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [plsrc_pkg::IDX_W-1:0]     point_index,
  input  logic [plsrc_pkg::TIME_W-1:0]    point_time,
  input  logic [plsrc_pkg::VOLT_W-1:0]    point_volts,
  input  logic [plsrc_pkg::TIME_W-1:0]    query_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [plsrc_pkg::VOLT_W-1:0]    volts_out,
  output logic [plsrc_pkg::REGION_W-1:0]  region
);

  import plsrc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int RW = TIME_W + VOLT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_FIN
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    points_in_use;
  logic [AW-1:0]       ptr;
  logic [AW-1:0]       cur;
  logic [AW-1:0]       last;
  logic [TIME_W-1:0]   q;
  logic [TIME_W-1:0]   t0;
  logic [TIME_W-1:0]   tp;
  logic [VOLT_W-1:0]   vp;
  logic [VOLT_W-1:0]   v1;
  logic                neg;
  logic [TIME_W-1:0]   mag;
  logic [TIME_W-1:0]   dt;
  logic [TIME_W-1:0]   span;
  logic [PROD_W-1:0]   prod;
  logic [VOLT_W-1:0]   res_v;
  logic [REGION_W-1:0] res_r;

  logic                accept;
  logic                ram_we;
  logic [RW-1:0]       rdata;
  logic [TIME_W-1:0]   rt;
  logic [VOLT_W-1:0]   rv;
  logic [CNT_W-1:0]    cnt_c;
  logic [AW-1:0]       last_c;
  logic [TIME_W-1:0]   t0_eff;
  logic                seg_hit;
  logic [TIME_W-1:0]   span_c;
  logic [TIME_W-1:0]   dt_c;
  logic [VOLT_W:0]     dv_c;
  logic [VOLT_W:0]     mag_c;
  logic [PROD_W-1:0]   prod_c;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // slots at or beyond the table depth are dropped
  assign ram_we   = accept && (op == OP_WRITE) && (32'(point_index) < MAX_POINTS);

  plsrc_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(point_index)),
    .wdata ({point_time, point_volts}),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign rt = rdata[RW-1:VOLT_W];
  assign rv = rdata[VOLT_W-1:0];

  // clamp point count to 1..MAX_POINTS
  assign cnt_c  = (points_in_use == '0) ? CNT_W'(1) : points_in_use;
  assign last_c = (32'(cnt_c) > MAX_POINTS) ? AW'(MAX_POINTS - 1)
                                            : AW'(cnt_c - CNT_W'(1));

  // scan datapath: rdata is entry cur, tp/vp is entry cur-1
  assign t0_eff  = (cur == '0) ? rt : t0;
  assign seg_hit = (cur != '0) && (tp <= q) && (q <= rt);
  assign span_c  = rt - tp;
  assign dt_c    = q - tp;
  assign dv_c    = {rv[VOLT_W-1], rv} - {vp[VOLT_W-1], vp};
  assign mag_c   = dv_c[VOLT_W] ? (VOLT_W+1)'(-dv_c) : dv_c;
  assign prod_c  = PROD_W'(mag) * PROD_W'(dt);

  assign div_req.start    = (state == S_DIVGO);
  assign div_req.dividend = prod;
  assign div_req.divisor  = span;

  plsrc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      points_in_use <= CNT_W'(1);
    end else begin
      if (cfg_we) begin
        points_in_use <= cfg_wdata;
      end
      // in S_FIN a transfer is replaced by the next result below
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (op == OP_QUERY)) begin
            q     <= query_time;
            last  <= last_c;
            ptr   <= '0;
            cur   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (ptr != last) begin
            ptr <= ptr + AW'(1);
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          tp <= rt;
          vp <= rv;
          if (cur == '0) begin
            t0 <= rt;
          end
          if (seg_hit) begin
            if (span_c == '0) begin
              res_v <= vp;
              res_r <= REGION_INSIDE;
              state <= S_FIN;
            end else begin
              v1    <= vp;
              neg   <= dv_c[VOLT_W];
              mag   <= mag_c[TIME_W-1:0];
              dt    <= dt_c;
              span  <= span_c;
              state <= S_MUL;
            end
          end else if (cur == last) begin
            // last point paired with itself, then out-of-range handling
            if (q == rt) begin
              res_v <= rv;
              res_r <= REGION_INSIDE;
            end else if (q < t0_eff) begin
              res_v <= '0;
              res_r <= REGION_BEFORE;
            end else begin
              res_v <= rv;
              res_r <= REGION_AFTER;
            end
            state <= S_FIN;
          end else begin
            cur <= cur + AW'(1);
            if (ptr != last) begin
              ptr <= ptr + AW'(1);
            end
          end
        end
        S_MUL: begin
          prod  <= prod_c;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_v <= neg ? (v1 - div_rsp.quotient) : (v1 + div_rsp.quotient);
            res_r <= REGION_INSIDE;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            volts_out <= res_v;
            region    <= res_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/plsrc_ram.sv
// ----------------------------------------------------------------------------
// plsrc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plsrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/plsrc_div.sv
// ----------------------------------------------------------------------------
// plsrc_div: serial restoring divider
// One quotient bit per cycle; expects the dividend's upper half below the
// divisor, so the quotient fits in QUOT_W bits. done pulses one cycle.
// ----------------------------------------------------------------------------
module plsrc_div (
  input  logic                clk,
  input  logic                rst,
  input  plsrc_pkg::div_req_t req,
  output plsrc_pkg::div_rsp_t rsp
);

  import plsrc_pkg::*;

  localparam int SW = $clog2(QUOT_W);

  logic              busy;
  logic              done;
  logic [SW-1:0]     steps;
  logic [TIME_W-1:0] divisor;
  logic [TIME_W-1:0] rem;
  logic [QUOT_W-1:0] low;

  logic [TIME_W:0]   rem_sh;
  logic              ge;
  logic [TIME_W:0]   diff;

  // low holds the remaining dividend bits and collects quotient bits
  assign rem_sh = {rem, low[QUOT_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        steps   <= SW'(QUOT_W - 1);
        divisor <= req.divisor;
        rem     <= req.dividend[PROD_W-1:QUOT_W];
        low     <= req.dividend[QUOT_W-1:0];
      end else if (busy) begin
        rem   <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        low   <= {low[QUOT_W-2:0], ge};
        steps <= steps - SW'(1);
        if (steps == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = low;

endmodule
